@@ src/vau_pkg.sv @@
// Shared types and constants for the three-component vector arithmetic unit.
package vau_pkg;

    typedef logic signed [31:0] word_t;

    typedef enum logic [3:0] {
        OP_VADD  = 4'd0,
        OP_VSUB  = 4'd1,
        OP_VMUL  = 4'd2,
        OP_VDIV  = 4'd3,
        OP_SADD  = 4'd4,
        OP_SSUB  = 4'd5,
        OP_RSUB  = 4'd6,
        OP_SMUL  = 4'd7,
        OP_SDIV  = 4'd8,
        OP_DOT   = 4'd9,
        OP_CROSS = 4'd10,
        OP_LENSQ = 4'd11,
        OP_LEN   = 4'd12,
        OP_UNIT  = 4'd13
    } op_t;

    typedef enum logic [3:0] {
        CL_ADDSUB,
        CL_MUL,
        CL_DIV,
        CL_DOT,
        CL_CROSS,
        CL_SQR,
        CL_LEN,
        CL_UNIT,
        CL_NONE
    } cls_t;

    typedef struct packed {
        logic [3:0] op;
        cls_t       cls;
        word_t      ax;
        word_t      ay;
        word_t      az;
        word_t      bx;
        word_t      by;
        word_t      bz;
        word_t      d;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_ACC,
        ST_SQRT,
        ST_DIVSET,
        ST_DIVWAIT,
        ST_DONE
    } state_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

@@ src/vau_front.sv @@
// Front part: accepts requests, sign-extends and classifies them, and queues them.
module vau_front #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          operation,
    input  logic [31:0]         a_x,
    input  logic [31:0]         a_y,
    input  logic [31:0]         a_z,
    input  logic [31:0]         b_x,
    input  logic [31:0]         b_y,
    input  logic [31:0]         b_z,
    input  logic [31:0]         scalar_in,
    input  logic                pop,
    output logic                q_valid,
    output vau_pkg::item_t      q_item
);
    import vau_pkg::*;

    localparam int SH = 32 - W;

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_next;
    logic                  push;
    item_t                 new_item;

    function automatic word_t sx(input logic [31:0] f);
        word_t t;
        t = word_t'(f << SH);
        return t >>> SH;
    endfunction

    always_comb
    begin
        new_item.op = operation;
        new_item.ax = sx(a_x);
        new_item.ay = sx(a_y);
        new_item.az = sx(a_z);
        new_item.bx = sx(b_x);
        new_item.by = sx(b_y);
        new_item.bz = sx(b_z);
        new_item.d  = sx(scalar_in);
        case (operation)
            OP_VADD, OP_VSUB, OP_SADD, OP_SSUB, OP_RSUB: new_item.cls = CL_ADDSUB;
            OP_VMUL, OP_SMUL: new_item.cls = CL_MUL;
            OP_VDIV, OP_SDIV: new_item.cls = CL_DIV;
            OP_DOT:   new_item.cls = CL_DOT;
            OP_CROSS: new_item.cls = CL_CROSS;
            OP_LENSQ: new_item.cls = CL_SQR;
            OP_LEN:   new_item.cls = CL_LEN;
            OP_UNIT:  new_item.cls = CL_UNIT;
            default:  new_item.cls = CL_NONE;
        endcase
    end

    assign busy    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ src/vau_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
module vau_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [33:0] rem_shift;
    logic        qbit;
    logic [33:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg[32:0], num_reg[63]};
        qbit      = (rem_shift >= {1'b0, den_reg});
        rem_next  = qbit ? rem_shift - {1'b0, den_reg} : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

@@ src/vau_sqrt.sv @@
// Integer square root, one result bit per cycle.
module vau_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] s_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [64:0] trial;
    logic        take;

    always_comb
    begin
        trial = {1'b0, r_reg} + {1'b0, bit_reg};
        take  = ({1'b0, s_reg} >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                s_reg <= s_reg - trial[63:0];
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

@@ src/vau_back.sv @@
// Back part: sequences one queued request through the adder, multiplier, root and divider.
module vau_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  vau_pkg::item_t      q_item,
    output logic                pop,
    output logic                done,
    output logic [31:0]         result_x,
    output logic [31:0]         result_y,
    output logic [31:0]         result_z,
    output logic [31:0]         result_scalar,
    output logic                divide_by_zero,
    output logic                overflow
);
    import vau_pkg::*;

    localparam logic signed [65:0] MAXV = (66'sd1 <<< (W - 1)) - 66'sd1;
    localparam logic signed [65:0] MINV = -(66'sd1 <<< (W - 1));

    state_t              state_reg, state_next;
    item_t               cur_reg, cur_next;
    logic [2:0]          t_reg, t_next;
    logic [1:0]          comp_reg, comp_next;
    logic signed [65:0]  acc_reg, acc_next;
    logic signed [63:0]  prod_reg;
    logic                neg_reg;
    word_t               res_reg [4];
    word_t               res_next [4];
    logic                dz_reg, dz_next;
    logic                ovf_reg, ovf_next;
    logic [31:0]         len_reg, len_next;
    logic                done_reg;
    word_t               out_reg [4];
    logic                out_dz_reg;
    logic                out_ovf_reg;

    word_t               mx, my;
    logic                mneg;
    logic signed [65:0]  acc_sum;
    logic [32:0]         fin;
    logic                div_start, div_done;
    logic [63:0]         div_dividend, div_q;
    logic [32:0]         div_divisor;
    logic                div_neg;
    logic                sqrt_start, sqrt_done;
    logic [31:0]         sqrt_root;
    word_t               da, db;
    logic [32:0]         da_mag, db_mag;
    logic signed [65:0]  add_v [3];
    logic [32:0]         add_s [3];
    logic signed [65:0]  q66;
    logic [32:0]         qs;
    logic [32:0]         lens;

    function automatic logic [32:0] sat66(input logic signed [65:0] v);
        if (v > MAXV)
        begin
            return {1'b1, MAXV[31:0]};
        end
        else if (v < MINV)
        begin
            return {1'b1, MINV[31:0]};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] mag(input word_t v);
        logic signed [32:0] e;
        e = 33'(v);
        return v[31] ? 33'(-e) : 33'(e);
    endfunction

    vau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    vau_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_sum[63:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        mx   = cur_reg.ax;
        my   = cur_reg.bx;
        mneg = 1'b0;
        case (cur_reg.cls)
            CL_CROSS:
            begin
                mneg = t_reg[0];
                case (t_reg)
                    3'd0:    begin mx = cur_reg.ay; my = cur_reg.bz; end
                    3'd1:    begin mx = cur_reg.az; my = cur_reg.by; end
                    3'd2:    begin mx = cur_reg.az; my = cur_reg.bx; end
                    3'd3:    begin mx = cur_reg.ax; my = cur_reg.bz; end
                    3'd4:    begin mx = cur_reg.ax; my = cur_reg.by; end
                    default: begin mx = cur_reg.ay; my = cur_reg.bx; end
                endcase
            end
            CL_SQR, CL_LEN, CL_UNIT:
            begin
                case (t_reg)
                    3'd0:    begin mx = cur_reg.ax; my = cur_reg.ax; end
                    3'd1:    begin mx = cur_reg.ay; my = cur_reg.ay; end
                    default: begin mx = cur_reg.az; my = cur_reg.az; end
                endcase
            end
            default:
            begin
                case (t_reg)
                    3'd0:    begin mx = cur_reg.ax; my = cur_reg.bx; end
                    3'd1:    begin mx = cur_reg.ay; my = cur_reg.by; end
                    default: begin mx = cur_reg.az; my = cur_reg.bz; end
                endcase
                if (cur_reg.op == OP_SMUL)
                begin
                    my = cur_reg.d;
                end
            end
        endcase
    end

    always_comb
    begin
        acc_sum = acc_reg + (neg_reg ? -66'(prod_reg) : 66'(prod_reg));
        fin     = sat66(acc_sum >>> F);
    end

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin da = cur_reg.ax; db = cur_reg.bx; end
            2'd1:    begin da = cur_reg.ay; db = cur_reg.by; end
            default: begin da = cur_reg.az; db = cur_reg.bz; end
        endcase
        if (cur_reg.op == OP_SDIV)
        begin
            db = cur_reg.d;
        end
        da_mag = mag(da);
        db_mag = (cur_reg.cls == CL_UNIT) ? {1'b0, len_reg} : mag(db);
        div_neg = (cur_reg.cls == CL_UNIT) ? da[31] : (da[31] ^ db[31]);
        div_dividend = {31'b0, da_mag} << F;
        div_divisor  = db_mag;
        q66 = div_neg ? -66'(div_q) : 66'(div_q);
        qs  = sat66(q66);
        lens = sat66(66'(sqrt_root));
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            add_v[c] = '0;
            add_s[c] = '0;
        end
        add_v[0] = 66'(cur_reg.ax);
        add_v[1] = 66'(cur_reg.ay);
        add_v[2] = 66'(cur_reg.az);
        for (int c = 0; c < 3; c++)
        begin
            case (cur_reg.op)
                OP_VADD:
                    add_v[c] = add_v[c] + 66'(c == 0 ? cur_reg.bx :
                                              c == 1 ? cur_reg.by : cur_reg.bz);
                OP_VSUB:
                    add_v[c] = add_v[c] - 66'(c == 0 ? cur_reg.bx :
                                              c == 1 ? cur_reg.by : cur_reg.bz);
                OP_SADD: add_v[c] = add_v[c] + 66'(cur_reg.d);
                OP_SSUB: add_v[c] = add_v[c] - 66'(cur_reg.d);
                default: add_v[c] = 66'(cur_reg.d) - add_v[c];
            endcase
            add_s[c] = sat66(add_v[c]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        t_next     = t_reg;
        comp_next  = comp_reg;
        acc_next   = acc_reg;
        dz_next    = dz_reg;
        ovf_next   = ovf_reg;
        len_next   = len_reg;
        for (int i = 0; i < 4; i++)
        begin
            res_next[i] = res_reg[i];
        end
        pop        = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    cur_next  = q_item;
                    t_next    = '0;
                    comp_next = '0;
                    acc_next  = '0;
                    dz_next   = 1'b0;
                    ovf_next  = 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        res_next[i] = '0;
                    end
                    case (q_item.cls)
                        CL_ADDSUB: state_next = ST_ADD;
                        CL_DIV:    state_next = ST_DIVSET;
                        CL_NONE:   state_next = ST_DONE;
                        default:   state_next = ST_MUL;
                    endcase
                end
            end
            ST_ADD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    res_next[c] = add_s[c][31:0];
                end
                ovf_next   = add_s[0][32] | add_s[1][32] | add_s[2][32];
                state_next = ST_DONE;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                t_next     = t_reg + 1'b1;
                state_next = ST_MUL;
                case (cur_reg.cls)
                    CL_MUL:
                    begin
                        res_next[t_reg[1:0]] = fin[31:0];
                        ovf_next = ovf_reg | fin[32];
                        acc_next = '0;
                        if (t_reg == 3'd2)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    CL_CROSS:
                    begin
                        if (t_reg[0])
                        begin
                            res_next[t_reg[2:1]] = fin[31:0];
                            ovf_next = ovf_reg | fin[32];
                            acc_next = '0;
                        end
                        else
                        begin
                            acc_next = acc_sum;
                        end
                        if (t_reg == 3'd5)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    CL_LEN, CL_UNIT:
                    begin
                        acc_next = acc_sum;
                        if (t_reg == 3'd2)
                        begin
                            sqrt_start = 1'b1;
                            state_next = ST_SQRT;
                        end
                    end
                    default:
                    begin
                        acc_next = acc_sum;
                        if (t_reg == 3'd2)
                        begin
                            res_next[3] = fin[31:0];
                            ovf_next    = fin[32];
                            state_next  = ST_DONE;
                        end
                    end
                endcase
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    len_next = sqrt_root;
                    if (cur_reg.cls == CL_LEN)
                    begin
                        state_next  = ST_DONE;
                        res_next[3] = lens[31:0];
                        ovf_next    = lens[32];
                    end
                    else if (sqrt_root == '0)
                    begin
                        dz_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        comp_next  = '0;
                        state_next = ST_DIVSET;
                    end
                end
            end
            ST_DIVSET:
            begin
                if (db_mag == '0)
                begin
                    dz_next = 1'b1;
                    res_next[comp_reg] = da[31] ? MINV[31:0] : MAXV[31:0];
                    comp_next  = comp_reg + 1'b1;
                    state_next = (comp_reg == 2'd2) ? ST_DONE : ST_DIVSET;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVWAIT;
                end
            end
            ST_DIVWAIT:
            begin
                if (div_done)
                begin
                    res_next[comp_reg] = qs[31:0];
                    ovf_next   = ovf_reg | qs[32];
                    comp_next  = comp_reg + 1'b1;
                    state_next = (comp_reg == 2'd2) ? ST_DONE : ST_DIVSET;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        t_reg    <= t_next;
        comp_reg <= comp_next;
        acc_reg  <= acc_next;
        dz_reg   <= dz_next;
        ovf_reg  <= ovf_next;
        len_reg  <= len_next;
        prod_reg <= mx * my;
        neg_reg  <= mneg;
        for (int i = 0; i < 4; i++)
        begin
            res_reg[i] <= res_next[i];
        end
        if (state_reg == ST_DONE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                out_reg[i] <= res_reg[i];
            end
            out_dz_reg  <= dz_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign done           = done_reg;
    assign result_x       = out_reg[0];
    assign result_y       = out_reg[1];
    assign result_z       = out_reg[2];
    assign result_scalar  = out_reg[3];
    assign divide_by_zero = out_dz_reg;
    assign overflow       = out_ovf_reg;

endmodule

@@ src/vec3_arithmetic_unit.sv @@
// Top level of the three-component vector arithmetic unit.
//
// Channel   Handshake            Payload
// request   start / busy         operation, a_x..a_z, b_x..b_z, scalar_in
// result    done (one cycle)     result_x..z, result_scalar, divide_by_zero, overflow
//
// A request is taken when start is high and busy is low; up to four wait in a queue.
// The sequencer works on one request at a time: add and subtract, each product term, the
// root and each divided component (in the shared divider) pass through it in turn; the
// result is registered as the sequencer finishes, and done rises with it.
// Reset empties the queue and returns the sequencer to idle.
// Results cannot be held off; busy rises only when the queue is full.
module vec3_arithmetic_unit #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  operation,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] scalar_in,
    output logic        done,
    output logic [31:0] result_x,
    output logic [31:0] result_y,
    output logic [31:0] result_z,
    output logic [31:0] result_scalar,
    output logic        divide_by_zero,
    output logic        overflow
);
    import vau_pkg::*;

    localparam int W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int F = (FRACTION_BITS > 30) ? 30 : FRACTION_BITS;

    logic  q_valid;
    logic  pop;
    item_t q_item;

    vau_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .scalar_in (scalar_in),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    vau_back #(.W(W), .F(F)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .done           (done),
        .result_x       (result_x),
        .result_y       (result_y),
        .result_z       (result_z),
        .result_scalar  (result_scalar),
        .divide_by_zero (divide_by_zero),
        .overflow       (overflow)
    );

endmodule
